// ----- rtl/rckt_pkg.sv -----
// ----------------------------------------------------------------------------
// rckt_pkg: shared types and constants of the reference-counted key table
// Table geometry, entry layout, operation and status codes, state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package rckt_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned RefW       = 8;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned SlotW      = 6;
  localparam int unsigned StatusW    = 4;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_LOOKUP   = 2'd2,
    MODE_LOOKUP_B = 2'd3   // undefined selector, behaves as lookup
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 4'd0,
    ST_ADD_FOUND = 4'd1,
    ST_ALREADY   = 4'd2,
    ST_HIT       = 4'd3,
    ST_MISS      = 4'd4,
    ST_NOT_FOUND = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_ZERO_KEY  = 4'd7,
    ST_FULL      = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [RefW-1:0] refs;
  } entry_t;

  function automatic logic [RefW-1:0] sat_inc(input logic [RefW-1:0] v);
    logic [RefW-1:0] r;
    r = (v == {RefW{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rckt_ram.sv -----
// ----------------------------------------------------------------------------
// rckt_ram: entry store of the key table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rckt_ram
  import rckt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire entry_t          wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output entry_t               rdata_o
);

  entry_t mem_q [TableDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/refcounted_key_table_top.sv -----
// ----------------------------------------------------------------------------
// refcounted_key_table_top: reference-counted key table
// Add, remove and lookup of keys with per-slot reference counts, by a
// sequential scan over the slot store with one shared key comparator.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                         tuser
//  s_axis    in   key[31:0] start_count[39:32]  mode[1:0] already_listed[2]
//  m_axis    out  slot[5:0] ref_count[13:6]     status[3:0] listed[4]
//
//  One item at a time. A scan reads one slot per cycle through the store's
//  read port into the key comparator: a hit at slot i ends the scan there, a
//  miss or an insert scans all TableDepth slots. Then follow one update
//  state and one response state; early exits go straight to the response.
//  Reset clears all valid bits and the occupancy count at once.
//  A stalled result holds in the output register; no new beat is taken
//  until it is delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_key_table_top
  import rckt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // key[31:0], start_count[39:32]
  input  wire logic [2:0]  s_axis_tuser,   // mode[1:0], already_listed[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // slot[5:0], ref_count[13:6], zero
  output logic [4:0]       m_axis_tuser    // status[3:0], listed[4]
);

  state_e state_q, state_d;

  // captured request
  mode_e           mode_q;
  logic [KeyW-1:0] key_q;
  logic [RefW-1:0] start_q;

  logic [TableDepth-1:0] valid_q;
  logic [CntW-1:0]       cnt_q;

  // scan pipeline
  logic [IdxW-1:0] iss_idx_q;
  logic            iss_done_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_valid_q;
  logic            free_fnd_q;
  logic [IdxW-1:0] free_idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [RefW-1:0] hit_refs_q;

  // result register
  status_e          res_status_q;
  logic [SlotW-1:0] res_slot_q;
  logic [RefW-1:0]  res_refs_q;
  logic             res_listed_q;

  logic            in_fire;
  mode_e           in_mode;
  logic [KeyW-1:0] in_key;
  logic            in_listed;
  logic [RefW-1:0] in_start;

  logic            early;
  status_e         early_status;
  logic [RefW-1:0] early_refs;
  logic            early_listed;

  entry_t          rd_entry;
  logic            cmp_hit;
  logic            cmp_last;
  logic            scan_end;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            set_valid;
  logic            clr_valid;
  status_e         upd_status;
  logic [IdxW-1:0] upd_idx;
  logic [RefW-1:0] upd_refs;
  logic            upd_listed;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_mode   = mode_e'(s_axis_tuser[1:0]);
  assign in_listed = s_axis_tuser[2];
  assign in_key    = KeyW'(s_axis_tdata[31:0]);
  assign in_start  = s_axis_tdata[39:32];

  // requests answered without a scan
  always_comb begin
    early        = 1'b0;
    early_status = ST_ZERO_KEY;
    early_refs   = '0;
    early_listed = 1'b0;
    unique case (in_mode)
      MODE_ADD: begin
        if (in_key == '0) begin
          early = 1'b1;
        end else if (in_listed) begin
          early        = 1'b1;
          early_status = ST_ALREADY;
          early_refs   = in_start;
          early_listed = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (in_key == '0) begin
          early = 1'b1;
        end else if (cnt_q == '0) begin
          early        = 1'b1;
          early_status = ST_EMPTY;
        end
      end
      default: begin
        early = 1'b0;
      end
    endcase
  end

  // shared key comparator on the read data of the previous cycle
  assign cmp_hit  = cmp_vld_q && cmp_valid_q && (rd_entry.key == key_q);
  assign cmp_last = cmp_vld_q && (cmp_idx_q == IdxW'(TableDepth - 1));
  assign scan_end = cmp_hit || cmp_last;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = early ? S_RESP : S_SCAN;
      S_SCAN:   if (scan_end) state_d = S_UPDATE;
      S_UPDATE: state_d = S_RESP;
      S_RESP:   if (m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs and update decode
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_RESP);
    ram_we        = 1'b0;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    upd_status    = ST_MISS;
    upd_idx       = hit_idx_q;
    upd_refs      = sat_inc(hit_refs_q);
    upd_listed    = 1'b0;
    if (state_q == S_UPDATE) begin
      unique case (mode_q)
        MODE_ADD: begin
          if (hit_q) begin
            ram_we     = 1'b1;
            upd_status = ST_ADD_FOUND;
            upd_listed = 1'b1;
          end else if (free_fnd_q) begin
            ram_we     = 1'b1;
            set_valid  = 1'b1;
            upd_idx    = free_idx_q;
            upd_refs   = sat_inc(start_q);
            upd_status = ST_INSERTED;
            upd_listed = 1'b1;
          end else begin
            upd_status = ST_FULL;
          end
        end
        MODE_REMOVE: begin
          if (!hit_q) begin
            upd_status = ST_NOT_FOUND;
          end else if (hit_refs_q <= RefW'(1)) begin
            clr_valid  = 1'b1;
            upd_status = ST_HIT;
            upd_refs   = '0;
          end else begin
            ram_we     = 1'b1;
            upd_status = ST_HIT;
            upd_refs   = hit_refs_q - 1'b1;
            upd_listed = 1'b1;
          end
        end
        default: begin
          if (hit_q) begin
            ram_we     = 1'b1;
            upd_status = ST_HIT;
            upd_listed = 1'b1;
          end
        end
      endcase
    end
    ram_waddr      = upd_idx;
    ram_wdata.key  = key_q;
    ram_wdata.refs = upd_refs;
  end

  rckt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (iss_idx_q),
    .rdata_o (rd_entry)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      cnt_q      <= '0;
      iss_done_q <= 1'b0;
      cmp_vld_q  <= 1'b0;
      free_fnd_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        iss_done_q <= 1'b0;
        cmp_vld_q  <= 1'b0;
        free_fnd_q <= 1'b0;
        hit_q      <= 1'b0;
      end else if (state_q == S_SCAN) begin
        // advance the read address, compare what came back
        cmp_vld_q <= !iss_done_q;
        if (iss_idx_q == IdxW'(TableDepth - 1)) begin
          iss_done_q <= 1'b1;
        end
        if (cmp_vld_q && !cmp_valid_q && !free_fnd_q) begin
          free_fnd_q <= 1'b1;
        end
        if (cmp_hit) begin
          hit_q <= 1'b1;
        end
      end
      if (set_valid) begin
        valid_q[upd_idx] <= 1'b1;
        cnt_q            <= cnt_q + 1'b1;
      end else if (clr_valid) begin
        valid_q[upd_idx] <= 1'b0;
        cnt_q            <= cnt_q - 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q       <= in_mode;
      key_q        <= in_key;
      start_q      <= in_start;
      iss_idx_q    <= '0;
      res_status_q <= early_status;
      res_slot_q   <= '0;
      res_refs_q   <= early_refs;
      res_listed_q <= early_listed;
    end else if (state_q == S_SCAN) begin
      iss_idx_q   <= iss_idx_q + 1'b1;
      cmp_idx_q   <= iss_idx_q;
      cmp_valid_q <= valid_q[iss_idx_q];
      if (cmp_vld_q && !cmp_valid_q && !free_fnd_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cmp_hit) begin
        hit_idx_q  <= cmp_idx_q;
        hit_refs_q <= rd_entry.refs;
      end
    end else if (state_q == S_UPDATE) begin
      res_status_q <= upd_status;
      res_slot_q   <= upd_listed || clr_valid ? SlotW'(upd_idx) : '0;
      res_refs_q   <= upd_listed ? upd_refs : '0;
      res_listed_q <= upd_listed;
    end
  end

  assign m_axis_tdata = {2'b00, res_refs_q, res_slot_q};
  assign m_axis_tuser = {res_listed_q, res_status_q};

`ifndef SYNTHESIS
  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(valid_q)))
    else $error("occupancy count disagrees with valid bits");

  a_one_side_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_update_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |=> (state_q == S_RESP))
    else $error("update not followed by response");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && hit_q) |-> valid_q[hit_idx_q])
    else $error("hit on a free slot");

  a_insert_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_valid |-> !valid_q[upd_idx] && (cnt_q != CntW'(TableDepth)))
    else $error("insert into an occupied slot or full table");
`endif

endmodule

`default_nettype wire
